// File: hdl/b32m_pkg.sv
package b32m_pkg;

    localparam int PFX_MAX = 16;
    localparam int SYM_MAX = 128;

    localparam int PFX_IDX_W = (PFX_MAX > 1) ? $clog2(PFX_MAX) : 1;
    localparam int PFX_CNT_W = $clog2(PFX_MAX + 1);
    localparam int SEQ_W     = (PFX_CNT_W > 3) ? PFX_CNT_W : 3;

    localparam logic [1:0] ACT_PFX  = 2'd0;
    localparam logic [1:0] ACT_DATA = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
    localparam logic [2:0] ERR_NO_PFX    = 3'd2;
    localparam logic [2:0] ERR_PFX_LONG  = 3'd3;
    localparam logic [2:0] ERR_DATA_LONG = 3'd4;
    localparam logic [2:0] ERR_OUT_LONG  = 3'd5;

    localparam logic [7:0] CHAR_SEP = 8'h31;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic [29:0] CHK_INIT     = 30'h1;
    localparam logic [29:0] BECH32M_XOR  = 30'h2bc830a3;
    localparam logic [29:0] GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PFX,
        ST_REPLAY,
        ST_SEP,
        ST_SYM,
        ST_PAD,
        ST_ZERO,
        ST_CHK,
        ST_ERR
    } state_t;

    function automatic logic [29:0] poly_step(input logic [29:0] c);
        logic [29:0] r;
        r = {c[24:0], 5'b00000};
        for (int i = 0; i < 5; i++)
        begin
            if (c[25 + i])
            begin
                r = r ^ GEN[i];
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] sym_char(input logic [4:0] s);
        logic [4:0] pos;
        pos = 5'd31 - s;
        return ALPHABET[{pos, 3'b000} +: 8];
    endfunction

endpackage

// File: hdl/bech32m_byte_encoder_core.sv
// Bech32m string encoder. Send prefix characters (action 0), then data bytes (action 1),
// then an end marker (action 2); characters come out one per transfer and the final one
// has last set with the status. A single checksum step unit does all polynomial work,
// one 5-bit symbol per cycle while the output is not stalled, and the block takes no new
// item until the current one is done. A data byte gives one output per symbol produced;
// the first data byte also replays the prefix and sends the separator. End: the replay
// if still due, a pad symbol if bits are left, 6 checksum steps and 6 checksum outputs.
// Each output waits while a result is not taken.
module bech32m_byte_encoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_out,
    output logic       last,
    output logic [2:0] status,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    b32m_pkg::state_t state_reg, state_next;

    logic [7:0]  limit_reg;
    logic [29:0] chk_reg, chk_next;
    logic [6:0]  pfx_store_reg [b32m_pkg::PFX_MAX];
    logic [b32m_pkg::PFX_CNT_W-1:0] pfx_cnt_reg, pfx_cnt_next;
    logic        data_ph_reg, data_ph_next;
    logic [11:0] bitbuf_reg, bitbuf_next;
    logic [3:0]  bitcnt_reg, bitcnt_next;
    logic [7:0]  sym_cnt_reg, sym_cnt_next;
    logic [2:0]  err_reg, err_next;
    logic [b32m_pkg::SEQ_W-1:0] seq_cnt_reg, seq_cnt_next;
    logic        end_reg, end_next;
    logic [7:0]  val_reg, val_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  char_out_reg, char_out_next;
    logic        last_reg, last_next;
    logic [2:0]  status_reg, status_next;

    logic        in_fire;
    logic        out_free;
    logic        out_load;
    logic        pfx_we;
    logic        bad_char;
    logic        pfx_full;
    logic        pad;
    logic [3:0]  bc_sum;
    logic [3:0]  bc_dec;
    logic [8:0]  sym_need;
    logic [8:0]  total;
    logic [2:0]  pfx_err;
    logic [2:0]  data_err;
    logic [2:0]  end_err;
    logic [b32m_pkg::PFX_IDX_W-1:0] rd_addr;
    logic [4:0]  step_sym;
    logic [29:0] chk_step;
    logic        replay_done;
    logic        seq_last;

    assign in_ready  = (state_reg == b32m_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign char_out  = char_out_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    assign bad_char = (value < 8'd33) || (value > 8'd126) ||
                      ((value >= 8'd65) && (value <= 8'd90));
    assign pfx_full = (pfx_cnt_reg >= b32m_pkg::PFX_CNT_W'(b32m_pkg::PFX_MAX));
    assign pad      = (bitcnt_reg != 4'd0);
    assign bc_sum   = bitcnt_reg + 4'd8;
    assign bc_dec   = bitcnt_reg - 4'd5;
    assign sym_need = {1'b0, sym_cnt_reg} + ((bc_sum >= 4'd10) ? 9'd2 : 9'd1);
    assign total    = 9'(pfx_cnt_reg) + {1'b0, sym_cnt_reg} + {8'd0, pad} + 9'd8;
    assign rd_addr  = b32m_pkg::PFX_IDX_W'(seq_cnt_reg - b32m_pkg::SEQ_W'(1));
    assign replay_done = (seq_cnt_reg == b32m_pkg::SEQ_W'(pfx_cnt_reg));
    assign seq_last    = (seq_cnt_reg == b32m_pkg::SEQ_W'(5));

    // item checks, all settled before anything is emitted
    always_comb
    begin
        if (bad_char || data_ph_reg)
            pfx_err = b32m_pkg::ERR_BAD_CHAR;
        else if (pfx_full)
            pfx_err = b32m_pkg::ERR_PFX_LONG;
        else
            pfx_err = b32m_pkg::ERR_NONE;

        if (!data_ph_reg && (pfx_cnt_reg == '0))
            data_err = b32m_pkg::ERR_NO_PFX;
        else if (sym_need > 9'(b32m_pkg::SYM_MAX))
            data_err = b32m_pkg::ERR_DATA_LONG;
        else
            data_err = b32m_pkg::ERR_NONE;

        if (err_reg != b32m_pkg::ERR_NONE)
            end_err = err_reg;
        else if (!data_ph_reg && (pfx_cnt_reg == '0))
            end_err = b32m_pkg::ERR_NO_PFX;
        else if (pad && ({1'b0, sym_cnt_reg} >= 9'(b32m_pkg::SYM_MAX)))
            end_err = b32m_pkg::ERR_DATA_LONG;
        else if (total > {1'b0, limit_reg})
            end_err = b32m_pkg::ERR_OUT_LONG;
        else
            end_err = b32m_pkg::ERR_NONE;
    end

    // symbol fed to the shared checksum unit
    always_comb
    begin
        unique case (state_reg)
            b32m_pkg::ST_PFX:
                step_sym = {2'b00, val_reg[7:5]};
            b32m_pkg::ST_REPLAY:
                step_sym = (seq_cnt_reg == '0) ? 5'd0 : pfx_store_reg[rd_addr][4:0];
            b32m_pkg::ST_SYM:
                step_sym = 5'(bitbuf_reg >> bc_dec);
            b32m_pkg::ST_PAD:
                step_sym = 5'({bitbuf_reg[3:0], 5'b00000} >> bitcnt_reg);
            default:
                step_sym = 5'd0;
        endcase
    end

    assign chk_step = b32m_pkg::poly_step(chk_reg) ^ {25'd0, step_sym};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            b32m_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (action)
                        b32m_pkg::ACT_PFX:
                            if (err_reg == b32m_pkg::ERR_NONE && pfx_err == b32m_pkg::ERR_NONE)
                                state_next = b32m_pkg::ST_PFX;
                        b32m_pkg::ACT_DATA:
                            if (err_reg == b32m_pkg::ERR_NONE && data_err == b32m_pkg::ERR_NONE)
                                state_next = data_ph_reg ? b32m_pkg::ST_SYM
                                                         : b32m_pkg::ST_REPLAY;
                        b32m_pkg::ACT_END:
                            if (end_err != b32m_pkg::ERR_NONE)
                                state_next = b32m_pkg::ST_ERR;
                            else if (!data_ph_reg)
                                state_next = b32m_pkg::ST_REPLAY;
                            else if (pad)
                                state_next = b32m_pkg::ST_PAD;
                            else
                                state_next = b32m_pkg::ST_ZERO;
                        default:
                            state_next = b32m_pkg::ST_IDLE;
                    endcase
                end
            end
            b32m_pkg::ST_PFX:
                if (out_free)
                    state_next = b32m_pkg::ST_IDLE;
            b32m_pkg::ST_REPLAY:
                if (replay_done)
                    state_next = b32m_pkg::ST_SEP;
            b32m_pkg::ST_SEP:
                if (out_free)
                    state_next = !end_reg ? b32m_pkg::ST_SYM
                               : (pad ? b32m_pkg::ST_PAD : b32m_pkg::ST_ZERO);
            b32m_pkg::ST_SYM:
                if (out_free && (bc_dec < 4'd5))
                    state_next = b32m_pkg::ST_IDLE;
            b32m_pkg::ST_PAD:
                if (out_free)
                    state_next = b32m_pkg::ST_ZERO;
            b32m_pkg::ST_ZERO:
                if (seq_last)
                    state_next = b32m_pkg::ST_CHK;
            b32m_pkg::ST_CHK:
                if (out_free && seq_last)
                    state_next = b32m_pkg::ST_IDLE;
            b32m_pkg::ST_ERR:
                if (out_free)
                    state_next = b32m_pkg::ST_IDLE;
            default:
                state_next = b32m_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        chk_next      = chk_reg;
        pfx_cnt_next  = pfx_cnt_reg;
        data_ph_next  = data_ph_reg;
        bitbuf_next   = bitbuf_reg;
        bitcnt_next   = bitcnt_reg;
        sym_cnt_next  = sym_cnt_reg;
        err_next      = err_reg;
        seq_cnt_next  = seq_cnt_reg;
        end_next      = end_reg;
        val_next      = val_reg;
        pfx_we        = 1'b0;
        out_load      = 1'b0;
        char_out_next = char_out_reg;
        last_next     = last_reg;
        status_next   = status_reg;

        unique case (state_reg)
            b32m_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (action)
                        b32m_pkg::ACT_PFX:
                            if (err_reg == b32m_pkg::ERR_NONE)
                            begin
                                err_next = pfx_err;
                                if (pfx_err == b32m_pkg::ERR_NONE)
                                begin
                                    pfx_we       = 1'b1;
                                    pfx_cnt_next = pfx_cnt_reg + b32m_pkg::PFX_CNT_W'(1);
                                    val_next     = value;
                                end
                            end
                        b32m_pkg::ACT_DATA:
                            if (err_reg == b32m_pkg::ERR_NONE)
                            begin
                                err_next = data_err;
                                if (data_err == b32m_pkg::ERR_NONE)
                                begin
                                    data_ph_next = 1'b1;
                                    bitbuf_next  = {bitbuf_reg[3:0], value};
                                    bitcnt_next  = bc_sum;
                                    seq_cnt_next = '0;
                                    end_next     = 1'b0;
                                end
                            end
                        b32m_pkg::ACT_END:
                        begin
                            err_next     = end_err;
                            seq_cnt_next = '0;
                            end_next     = 1'b1;
                        end
                        default:
                            end_next = end_reg;
                    endcase
                end
            end
            b32m_pkg::ST_PFX:
                if (out_free)
                begin
                    chk_next      = chk_step;
                    out_load      = 1'b1;
                    char_out_next = val_reg;
                    last_next     = 1'b0;
                    status_next   = b32m_pkg::ERR_NONE;
                end
            b32m_pkg::ST_REPLAY:
            begin
                chk_next     = chk_step;
                seq_cnt_next = replay_done ? '0 : seq_cnt_reg + b32m_pkg::SEQ_W'(1);
            end
            b32m_pkg::ST_SEP:
                if (out_free)
                begin
                    data_ph_next  = 1'b1;
                    out_load      = 1'b1;
                    char_out_next = b32m_pkg::CHAR_SEP;
                    last_next     = 1'b0;
                    status_next   = b32m_pkg::ERR_NONE;
                end
            b32m_pkg::ST_SYM:
                if (out_free)
                begin
                    chk_next      = chk_step;
                    bitcnt_next   = bc_dec;
                    sym_cnt_next  = sym_cnt_reg + 8'd1;
                    out_load      = 1'b1;
                    char_out_next = b32m_pkg::sym_char(step_sym);
                    last_next     = 1'b0;
                    status_next   = b32m_pkg::ERR_NONE;
                end
            b32m_pkg::ST_PAD:
                if (out_free)
                begin
                    chk_next      = chk_step;
                    bitcnt_next   = 4'd0;
                    sym_cnt_next  = sym_cnt_reg + 8'd1;
                    seq_cnt_next  = '0;
                    out_load      = 1'b1;
                    char_out_next = b32m_pkg::sym_char(step_sym);
                    last_next     = 1'b0;
                    status_next   = b32m_pkg::ERR_NONE;
                end
            b32m_pkg::ST_ZERO:
            begin
                chk_next     = seq_last ? (chk_step ^ b32m_pkg::BECH32M_XOR) : chk_step;
                seq_cnt_next = seq_last ? '0 : seq_cnt_reg + b32m_pkg::SEQ_W'(1);
            end
            b32m_pkg::ST_CHK:
                if (out_free)
                begin
                    chk_next      = {chk_reg[24:0], 5'b00000};
                    seq_cnt_next  = seq_cnt_reg + b32m_pkg::SEQ_W'(1);
                    out_load      = 1'b1;
                    char_out_next = b32m_pkg::sym_char(chk_reg[29:25]);
                    last_next     = seq_last;
                    status_next   = b32m_pkg::ERR_NONE;
                end
            b32m_pkg::ST_ERR:
                if (out_free)
                begin
                    out_load      = 1'b1;
                    char_out_next = b32m_pkg::CHAR_NUL;
                    last_next     = 1'b1;
                    status_next   = err_reg;
                end
            default:
                out_load = 1'b0;
        endcase

        // message done: back to a fresh message
        if (out_load && last_next)
        begin
            chk_next     = b32m_pkg::CHK_INIT;
            pfx_cnt_next = '0;
            data_ph_next = 1'b0;
            bitbuf_next  = '0;
            bitcnt_next  = '0;
            sym_cnt_next = '0;
            err_next     = b32m_pkg::ERR_NONE;
            seq_cnt_next = '0;
        end

        out_valid_next = out_load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= b32m_pkg::ST_IDLE;
            limit_reg     <= 8'd255;
            chk_reg       <= b32m_pkg::CHK_INIT;
            pfx_cnt_reg   <= '0;
            data_ph_reg   <= 1'b0;
            bitbuf_reg    <= '0;
            bitcnt_reg    <= '0;
            sym_cnt_reg   <= '0;
            err_reg       <= b32m_pkg::ERR_NONE;
            seq_cnt_reg   <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            chk_reg       <= chk_next;
            pfx_cnt_reg   <= pfx_cnt_next;
            data_ph_reg   <= data_ph_next;
            bitbuf_reg    <= bitbuf_next;
            bitcnt_reg    <= bitcnt_next;
            sym_cnt_reg   <= sym_cnt_next;
            err_reg       <= err_next;
            seq_cnt_reg   <= seq_cnt_next;
            end_reg       <= end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        char_out_reg <= char_out_next;
        last_reg     <= last_next;
        status_reg   <= status_next;
        if (pfx_we)
        begin
            pfx_store_reg[pfx_cnt_reg[b32m_pkg::PFX_IDX_W-1:0]] <= value[6:0];
        end
    end

`ifndef NO_ASSERTIONS
    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result register loaded while a result is waiting");

    // error status only on the final result
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != b32m_pkg::ERR_NONE)) |-> last)
        else $error("error status on a non-final result");

    // prefix count stays within the store
    a_pfx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pfx_cnt_reg <= b32m_pkg::PFX_CNT_W'(b32m_pkg::PFX_MAX))
        else $error("prefix count beyond the store");

    // leftover bits never form a whole symbol between items
    a_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == b32m_pkg::ST_IDLE) |-> (bitcnt_reg < 4'd5))
        else $error("whole symbol left in the bit buffer");

    // the symbol count never passes its limit
    a_sym_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, sym_cnt_reg} <= 9'(b32m_pkg::SYM_MAX))
        else $error("symbol count beyond limit");
`endif

endmodule

// File: verif/tb_bech32m_byte_encoder_core.sv
`timescale 1ns / 100ps

module tb_bech32m_byte_encoder_core;

    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
        logic [2:0] st;
    } char_xfer_t;

    localparam logic [255:0] B32_SET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 180;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS = 20;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] action;
    logic [7:0] value;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] char_out;
    logic       last;
    logic [2:0] status;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    // predictor state
    logic [29:0] chk_acc;
    logic [6:0]  hrp_chars [b32m_pkg::PFX_MAX];
    int          hrp_len;
    bit          in_payload;
    logic [11:0] bit_pool;
    int          pool_bits;
    int          sym_total;
    logic [2:0]  sticky_err;
    logic [7:0]  out_limit;

    char_xfer_t exp_chars [$];
    char_xfer_t want;

    int  err_count;
    int  chars_checked;
    int  msgs_done;
    int  items_sent;
    int  burst_left;
    bit  gaps_on;
    bit  hold_req;
    int  hold_left;
    int  pat_age;
    logic [15:0] stall_pat;

    bech32m_byte_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .last      (last),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [29:0] chk_next(input logic [29:0] c);
        logic [29:0] r;
        r = {c[24:0], 5'b00000};
        if (c[25])
            r = r ^ 30'h3b6a57b2;
        if (c[26])
            r = r ^ 30'h26508e6d;
        if (c[27])
            r = r ^ 30'h1ea119fa;
        if (c[28])
            r = r ^ 30'h3d4233dd;
        if (c[29])
            r = r ^ 30'h2a1462b3;
        return r;
    endfunction

    function automatic logic [7:0] sym_ascii(input logic [4:0] s);
        return B32_SET[(31 - s) * 8 +: 8];
    endfunction

    function automatic void clear_msg_state();
        chk_acc    = b32m_pkg::CHK_INIT;
        hrp_len    = 0;
        in_payload = 1'b0;
        bit_pool   = '0;
        pool_bits  = 0;
        sym_total  = 0;
        sticky_err = b32m_pkg::ERR_NONE;
    endfunction

    function automatic void push_char(input logic [7:0] c, input logic l, input logic [2:0] s);
        char_xfer_t x;
        x.ch  = c;
        x.lst = l;
        x.st  = s;
        exp_chars.push_back(x);
    endfunction

    function automatic logic [2:0] replay_prefix();
        if (hrp_len == 0)
            return b32m_pkg::ERR_NO_PFX;
        chk_acc = chk_next(chk_acc);
        for (int i = 0; i < hrp_len; i++)
            chk_acc = chk_next(chk_acc) ^ {25'd0, hrp_chars[i][4:0]};
        in_payload = 1'b1;
        return b32m_pkg::ERR_NONE;
    endfunction

    function automatic void predict_item(input logic [1:0] act, input logic [7:0] val);
        logic [29:0] chk_save;
        logic [4:0]  syms [2];
        logic [2:0]  e;
        logic [4:0]  s;
        int          nsym;
        bit          sep;
        nsym = 0;
        sep = 1'b0;
        chk_save = chk_acc;
        case (act)
            b32m_pkg::ACT_PFX:
            begin
                if (sticky_err == b32m_pkg::ERR_NONE)
                begin
                    if (in_payload || val < 8'd33 || val > 8'd126 ||
                        (val >= "A" && val <= "Z"))
                        sticky_err = b32m_pkg::ERR_BAD_CHAR;
                    else if (hrp_len >= b32m_pkg::PFX_MAX)
                        sticky_err = b32m_pkg::ERR_PFX_LONG;
                    else
                    begin
                        hrp_chars[hrp_len] = val[6:0];
                        hrp_len++;
                        chk_acc = chk_next(chk_acc) ^ {27'd0, val[7:5]};
                        push_char(val, 1'b0, b32m_pkg::ERR_NONE);
                    end
                end
            end
            b32m_pkg::ACT_DATA:
            begin
                if (sticky_err == b32m_pkg::ERR_NONE && !in_payload)
                begin
                    e = replay_prefix();
                    if (e != b32m_pkg::ERR_NONE)
                        sticky_err = e;
                    else
                        sep = 1'b1;
                end
                if (sticky_err == b32m_pkg::ERR_NONE)
                begin
                    bit_pool = {bit_pool[3:0], val};
                    pool_bits += 8;
                    while (pool_bits >= 5 && sticky_err == b32m_pkg::ERR_NONE)
                    begin
                        pool_bits -= 5;
                        if (sym_total >= b32m_pkg::SYM_MAX)
                        begin
                            sticky_err = b32m_pkg::ERR_DATA_LONG;
                            chk_acc = chk_save;
                        end
                        else
                        begin
                            syms[nsym] = 5'(bit_pool >> pool_bits);
                            chk_acc = chk_next(chk_acc) ^ {25'd0, syms[nsym]};
                            sym_total++;
                            nsym++;
                        end
                    end
                    if (sticky_err == b32m_pkg::ERR_NONE)
                    begin
                        bit_pool = {8'd0, bit_pool[3:0]};
                        if (sep)
                            push_char(b32m_pkg::CHAR_SEP, 1'b0, b32m_pkg::ERR_NONE);
                        for (int j = 0; j < nsym; j++)
                            push_char(sym_ascii(syms[j]), 1'b0, b32m_pkg::ERR_NONE);
                    end
                end
            end
            b32m_pkg::ACT_END:
            begin
                if (sticky_err == b32m_pkg::ERR_NONE && !in_payload)
                begin
                    sticky_err = replay_prefix();
                    sep = 1'b1;
                end
                if (sticky_err == b32m_pkg::ERR_NONE && pool_bits > 0)
                begin
                    if (sym_total >= b32m_pkg::SYM_MAX)
                        sticky_err = b32m_pkg::ERR_DATA_LONG;
                    else
                    begin
                        syms[0] = 5'(bit_pool << (5 - pool_bits));
                        chk_acc = chk_next(chk_acc) ^ {25'd0, syms[0]};
                        sym_total++;
                        nsym = 1;
                    end
                end
                if (sticky_err == b32m_pkg::ERR_NONE &&
                    hrp_len + sym_total + 8 > int'(out_limit))
                    sticky_err = b32m_pkg::ERR_OUT_LONG;
                if (sticky_err != b32m_pkg::ERR_NONE)
                    push_char(b32m_pkg::CHAR_NUL, 1'b1, sticky_err);
                else
                begin
                    for (int j = 0; j < 6; j++)
                        chk_acc = chk_next(chk_acc);
                    chk_acc = chk_acc ^ b32m_pkg::BECH32M_XOR;
                    if (sep)
                        push_char(b32m_pkg::CHAR_SEP, 1'b0, b32m_pkg::ERR_NONE);
                    if (nsym != 0)
                        push_char(sym_ascii(syms[0]), 1'b0, b32m_pkg::ERR_NONE);
                    for (int j = 0; j < 6; j++)
                    begin
                        s = 5'(chk_acc >> ((5 - j) * 5));
                        push_char(sym_ascii(s), (j == 5), b32m_pkg::ERR_NONE);
                    end
                end
                clear_msg_state();
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_hrp_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 126));
        while (c >= "A" && c <= "Z");
        return c;
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [7:0] val);
        int gap;
        @(negedge clk);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 10);
        end
        predict_item(act, val);
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        if (burst_left > 0)
            burst_left--;
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (exp_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] lim);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(negedge clk);
        cfg_we    <= 1'b0;
        out_limit = lim;
    endtask

    task automatic send_message(input int n_hrp, input int n_bytes);
        for (int i = 0; i < n_hrp; i++)
            send_item(b32m_pkg::ACT_PFX, pick_hrp_char());
        for (int i = 0; i < n_bytes; i++)
            send_item(b32m_pkg::ACT_DATA, 8'($urandom));
        send_item(b32m_pkg::ACT_END, 8'($urandom));
    endtask

    task automatic test_basic_message();
        gaps_on = 1'b0;
        send_item(b32m_pkg::ACT_PFX, "!");
        send_item(b32m_pkg::ACT_PFX, "~");
        send_item(b32m_pkg::ACT_PFX, "@");
        send_item(b32m_pkg::ACT_PFX, "[");
        send_item(b32m_pkg::ACT_PFX, "a");
        send_item(b32m_pkg::ACT_DATA, 8'h00);
        send_item(b32m_pkg::ACT_DATA, 8'hFF);
        send_item(b32m_pkg::ACT_DATA, 8'hA5);
        send_item(b32m_pkg::ACT_END, 8'h00);
        // prefix only, replay happens at end
        send_item(b32m_pkg::ACT_PFX, "z");
        send_item(b32m_pkg::ACT_END, 8'hFF);
        wait_drained();
    endtask

    task automatic test_prefix_errors();
        logic [7:0] bad [4];
        bad = '{8'd32, 8'd127, "A", "Z"};
        gaps_on = 1'b1;
        foreach (bad[i])
        begin
            send_item(b32m_pkg::ACT_PFX, "x");
            send_item(b32m_pkg::ACT_PFX, bad[i]);
            send_item(b32m_pkg::ACT_END, 8'h00);
        end
        // prefix character after data
        send_item(b32m_pkg::ACT_PFX, "x");
        send_item(b32m_pkg::ACT_DATA, 8'h3C);
        send_item(b32m_pkg::ACT_PFX, "y");
        send_item(b32m_pkg::ACT_END, 8'h00);
        // missing prefix
        send_item(b32m_pkg::ACT_DATA, 8'h11);
        send_item(b32m_pkg::ACT_END, 8'h00);
        send_item(b32m_pkg::ACT_END, 8'h00);
        // unused action in the middle of a message
        send_item(b32m_pkg::ACT_PFX, "q");
        send_item(ACT_UNUSED, 8'hFF);
        send_item(b32m_pkg::ACT_DATA, 8'h5A);
        send_item(b32m_pkg::ACT_END, 8'h00);
        // prefix overflow
        for (int i = 0; i <= b32m_pkg::PFX_MAX; i++)
            send_item(b32m_pkg::ACT_PFX, pick_hrp_char());
        send_item(b32m_pkg::ACT_END, 8'h00);
        wait_drained();
    endtask

    task automatic test_output_limit();
        gaps_on = 1'b1;
        write_limit(8'd10);
        send_item(b32m_pkg::ACT_PFX, "a");
        send_item(b32m_pkg::ACT_DATA, 8'h00);
        send_item(b32m_pkg::ACT_END, 8'h00);
        wait_drained();
        write_limit(8'd11);
        send_item(b32m_pkg::ACT_PFX, "a");
        send_item(b32m_pkg::ACT_DATA, 8'hFF);
        send_item(b32m_pkg::ACT_END, 8'h00);
        wait_drained();
        write_limit(8'd0);
        send_item(b32m_pkg::ACT_PFX, "a");
        send_item(b32m_pkg::ACT_END, 8'h00);
        wait_drained();
        write_limit(8'd255);
    endtask

    task automatic test_symbol_limit();
        gaps_on = 1'b1;
        // full symbol budget, then one byte too many
        send_message(1, 81);
        wait_drained();
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_req = 1'b1;
        send_message(2, 10);
        wait_drained();
    endtask

    task automatic test_random();
        int start;
        int n;
        logic [1:0] act;
        start = items_sent;
        gaps_on = 1'b1;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                wait_drained();
                case ($urandom_range(0, 5))
                    0: write_limit(8'd0);
                    1: write_limit(8'd255);
                    2: write_limit(8'($urandom_range(8, 30)));
                    default: write_limit(8'($urandom_range(30, 255)));
                endcase
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 6) != 0)
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, b32m_pkg::PFX_MAX)
                                                 : $urandom_range(1, 4);
                send_message(n, $urandom_range(0, 12));
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                begin
                    act = 2'($urandom_range(0, 3));
                    send_item(act, 8'($urandom));
                end
                send_item(b32m_pkg::ACT_END, 8'($urandom));
            end
        end
        wait_drained();
    endtask

    // receiver: rotating stall pattern, plus a long hold on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (pat_age == 0)
            begin
                pat_age = 48;
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : (16'($urandom) | 16'h0001);
            end
            pat_age--;
            out_ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    // check each output transfer against the oldest expected character
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_chars.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, got %h %b %0d",
                         $time, char_out, last, status);
                err_count++;
            end
            else
            begin
                want = exp_chars.pop_front();
                if (char_out !== want.ch)
                begin
                    $display("%0t: char_out expected %h actual %h", $time, want.ch, char_out);
                    err_count++;
                end
                if (last !== want.lst)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.lst, last);
                    err_count++;
                end
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                    err_count++;
                end
                chars_checked++;
                if (want.lst)
                    msgs_done++;
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = b32m_pkg::ACT_PFX;
        value      = 8'h00;
        out_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 8'h00;
        err_count  = 0;
        chars_checked = 0;
        msgs_done  = 0;
        items_sent = 0;
        burst_left = 0;
        gaps_on    = 1'b0;
        hold_req   = 1'b0;
        hold_left  = 0;
        pat_age    = 0;
        stall_pat  = 16'hFFFF;
        out_limit  = 8'd255;
        clear_msg_state();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_basic_message();
        test_prefix_errors();
        test_output_limit();
        test_symbol_limit();
        test_backpressure();
        test_random();

        $display("covered %0d input items and %0d messages, %0d output characters checked",
                 items_sent, msgs_done, chars_checked);
        $display("prefix errors, symbol and output limits, long receiver hold, random messages");
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hdl/b32m_pkg.sv
hdl/bech32m_byte_encoder_core.sv
verif/tb_bech32m_byte_encoder_core.sv
